// ===== hdl/bme_pkg.sv =====
`default_nettype none

package bme_pkg;

  localparam int WORD_BITS  = 64;
  localparam int WORD_COUNT = 64;
  localparam int SUB_W      = $clog2(WORD_BITS);
  localparam int ADDR_W     = $clog2(WORD_COUNT);
  localparam int OP_W       = 3;
  localparam int IDX_W      = 12;
  localparam int CNT_W      = 13;

  localparam logic [CNT_W-1:0] CAP        = CNT_W'(WORD_BITS * WORD_COUNT);
  localparam logic [CNT_W-1:0] BITS_RESET = CNT_W'(4096);
  localparam logic [SUB_W:0]   HI_FULL    = (SUB_W+1)'(WORD_BITS);

  localparam logic [OP_W-1:0] OP_READ  = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 3'd1;
  localparam logic [OP_W-1:0] OP_RANGE = 3'd2;
  localparam logic [OP_W-1:0] OP_FIRST = 3'd3;
  localparam logic [OP_W-1:0] OP_LAST  = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd5;

  typedef struct packed {
    logic [WORD_BITS-1:0] modified;
    logic                 any;
    logic [SUB_W-1:0]     first_sub;
    logic [SUB_W-1:0]     last_sub;
  } word_res_t;

endpackage

`default_nettype wire

// ===== hdl/bitmap_engine_with_find_first_last.sv =====
// Bit vector of 4096 bits held in a 64 x 64-bit word memory, with single-bit
// read/write, range write, find-first-set, find-last-set and clear-all.
// Input channel in_valid/in_ready carries op, value, index, range_end; the
// output channel out_valid/out_ready carries bit_value, found, found_index
// and error, one result word per request.
// bits_in_use is written through the APB port at byte address 0; it bounds
// index checks and scans and must only change while the block is idle.
// Timing: one memory word is read and, for writes, rewritten per cycle by a
// single shared mask/search unit. An accepted request goes from idle to a
// run state that works through the words it touches, then to a done state
// that moves the result into the output register; requests that need no
// memory access (errors, empty ranges, zero-limit scans, clear-all, spare
// ops) skip the run state. A new request is taken only once back in idle.
// Reset clears the whole map at once through per-word valid flags and sets
// bits_in_use to 4096; clear-all works the same way.
// The output register frees the engine while a result waits; if the
// receiver stalls with a second result finished, the engine holds it and
// accepts nothing until the output register drains.
`default_nettype none

module bitmap_engine_with_find_first_last (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [2:0]                   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [bme_pkg::OP_W-1:0]     op,
  input  wire logic                         value,
  input  wire logic [bme_pkg::IDX_W-1:0]    index,
  input  wire logic [bme_pkg::CNT_W-1:0]    range_end,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              bit_value,
  output logic                              found,
  output logic      [bme_pkg::IDX_W-1:0]    found_index,
  output logic                              error
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                     state;
  logic [bme_pkg::CNT_W-1:0]      bits_in_use;
  logic [bme_pkg::CNT_W-1:0]      lim;
  logic [bme_pkg::CNT_W-1:0]      lim_m1;
  logic [bme_pkg::CNT_W-1:0]      end_m1;

  logic [bme_pkg::OP_W-1:0]       op_q;
  logic                           value_q;
  logic [bme_pkg::ADDR_W-1:0]     cur;
  logic [bme_pkg::ADDR_W-1:0]     cur_step;
  logic [bme_pkg::ADDR_W-1:0]     first_w;
  logic [bme_pkg::ADDR_W-1:0]     last_w;
  logic [bme_pkg::SUB_W-1:0]      lo;
  logic [bme_pkg::SUB_W:0]        hi;

  logic                           acc_run;
  logic                           acc_err;
  logic                           acc_clear;
  logic [bme_pkg::ADDR_W-1:0]     first_next;
  logic [bme_pkg::ADDR_W-1:0]     last_next;
  logic [bme_pkg::ADDR_W-1:0]     start_next;
  logic [bme_pkg::SUB_W-1:0]      lo_next;
  logic [bme_pkg::SUB_W:0]        hi_next;

  logic                           r_bit;
  logic                           r_found;
  logic [bme_pkg::IDX_W-1:0]      r_idx;
  logic                           r_err;

  logic [bme_pkg::WORD_BITS-1:0]  mem [bme_pkg::WORD_COUNT];
  logic [bme_pkg::WORD_COUNT-1:0] word_valid;
  logic [bme_pkg::ADDR_W-1:0]     rd_addr;
  logic [bme_pkg::WORD_BITS-1:0]  rd_data;
  logic                           rd_vld;
  logic [bme_pkg::WORD_BITS-1:0]  word_in;
  logic                           wr_en;

  logic [bme_pkg::SUB_W-1:0]      lo_eff;
  logic [bme_pkg::SUB_W:0]        hi_eff;
  bme_pkg::word_res_t             res;

  // config port
  assign pready = 1'b1;
  assign prdata = paddr[2] ? '0 : 32'(bits_in_use);

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_in_use <= bme_pkg::BITS_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      bits_in_use <= pwdata[bme_pkg::CNT_W-1:0];
    end
  end

  assign lim    = (bits_in_use < bme_pkg::CAP) ? bits_in_use : bme_pkg::CAP;
  assign lim_m1 = lim - 1'b1;
  assign end_m1 = range_end - 1'b1;

  assign in_ready = (state == ST_IDLE);

  // request decode
  always_comb begin
    acc_run    = 1'b0;
    acc_err    = 1'b0;
    acc_clear  = 1'b0;
    first_next = bme_pkg::ADDR_W'(index >> bme_pkg::SUB_W);
    last_next  = bme_pkg::ADDR_W'(index >> bme_pkg::SUB_W);
    lo_next    = index[bme_pkg::SUB_W-1:0];
    hi_next    = {1'b0, index[bme_pkg::SUB_W-1:0]} + 1'b1;
    case (op)
      bme_pkg::OP_READ, bme_pkg::OP_WRITE: begin
        if ({1'b0, index} >= lim) acc_err = 1'b1;
        else acc_run = 1'b1;
      end
      bme_pkg::OP_RANGE: begin
        last_next = bme_pkg::ADDR_W'(end_m1 >> bme_pkg::SUB_W);
        hi_next   = {1'b0, end_m1[bme_pkg::SUB_W-1:0]} + 1'b1;
        if (({1'b0, index} > lim) || (range_end > lim)) acc_err = 1'b1;
        else if (range_end > {1'b0, index}) acc_run = 1'b1;
      end
      bme_pkg::OP_FIRST, bme_pkg::OP_LAST: begin
        first_next = '0;
        last_next  = bme_pkg::ADDR_W'(lim_m1 >> bme_pkg::SUB_W);
        lo_next    = '0;
        hi_next    = {1'b0, lim_m1[bme_pkg::SUB_W-1:0]} + 1'b1;
        acc_run    = (lim != '0);
      end
      bme_pkg::OP_CLEAR: acc_clear = 1'b1;
      default: ;
    endcase
  end

  assign start_next = (op == bme_pkg::OP_LAST) ? last_next : first_next;
  assign cur_step   = (op_q == bme_pkg::OP_LAST) ? cur - 1'b1 : cur + 1'b1;
  assign rd_addr    = (state == ST_IDLE) ? start_next : cur_step;

  // word memory with a registered read, addressed with the next word while the current one is worked on
  assign wr_en = (state == ST_RUN) &&
                 ((op_q == bme_pkg::OP_WRITE) || (op_q == bme_pkg::OP_RANGE));

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    rd_vld  <= word_valid[rd_addr];
    if (wr_en) mem[cur] <= res.modified;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
    end else if (in_valid && in_ready && acc_clear) begin
      word_valid <= '0;
    end else if (wr_en) begin
      word_valid[cur] <= 1'b1;
    end
  end

  assign word_in = rd_vld ? rd_data : '0;
  assign lo_eff  = (cur == first_w) ? lo : '0;
  assign hi_eff  = (cur == last_w) ? hi : bme_pkg::HI_FULL;

  bme_word_unit u_word (
    .word  (word_in),
    .lo    (lo_eff),
    .hi    (hi_eff),
    .value (value_q),
    .res   (res)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != ST_DONE)) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            op_q    <= op;
            value_q <= value;
            first_w <= first_next;
            last_w  <= last_next;
            lo      <= lo_next;
            hi      <= hi_next;
            cur     <= start_next;
            r_bit   <= 1'b0;
            r_found <= 1'b0;
            r_idx   <= '0;
            r_err   <= acc_err;
            state   <= acc_run ? ST_RUN : ST_DONE;
          end
        end
        ST_RUN: begin
          case (op_q)
            bme_pkg::OP_READ: begin
              r_bit <= res.any;
              state <= ST_DONE;
            end
            bme_pkg::OP_RANGE: begin
              if (cur == last_w) state <= ST_DONE;
              else cur <= cur_step;
            end
            bme_pkg::OP_FIRST: begin
              if (res.any) begin
                r_found <= 1'b1;
                r_idx   <= {cur, res.first_sub};
                state   <= ST_DONE;
              end else if (cur == last_w) begin
                state <= ST_DONE;
              end else begin
                cur <= cur_step;
              end
            end
            bme_pkg::OP_LAST: begin
              if (res.any) begin
                r_found <= 1'b1;
                r_idx   <= {cur, res.last_sub};
                state   <= ST_DONE;
              end else if (cur == first_w) begin
                state <= ST_DONE;
              end else begin
                cur <= cur_step;
              end
            end
            default: state <= ST_DONE;
          endcase
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            bit_value   <= r_bit;
            found       <= r_found;
            found_index <= r_idx;
            error       <= r_err;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_cur_in_span: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> ((cur >= first_w) && (cur <= last_w)))
    else $error("word pointer left the span of the request");

  a_err_not_found: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(error && found))
    else $error("error and found both set");

  a_clear_all: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (op == bme_pkg::OP_CLEAR)) |=> (word_valid == '0))
    else $error("clear-all left a word marked valid");

  a_found_idle_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && op_q != bme_pkg::OP_FIRST && op_q != bme_pkg::OP_LAST) |-> !r_found)
    else $error("found flagged for a non-search request");

endmodule

`default_nettype wire

// ===== hdl/bme_word_unit.sv =====
`default_nettype none

module bme_word_unit (
  input  wire logic [bme_pkg::WORD_BITS-1:0] word,
  input  wire logic [bme_pkg::SUB_W-1:0]     lo,
  input  wire logic [bme_pkg::SUB_W:0]       hi,
  input  wire logic                          value,
  output bme_pkg::word_res_t                 res
);

  logic [bme_pkg::WORD_BITS-1:0] ones;
  logic [bme_pkg::WORD_BITS-1:0] mask;
  logic [bme_pkg::WORD_BITS-1:0] masked;
  logic [bme_pkg::SUB_W-1:0]     first_sub;
  logic [bme_pkg::SUB_W-1:0]     last_sub;

  // sub-index 0 is the msb, so sub s sits at bit WORD_BITS-1-s
  assign ones   = '1;
  assign mask   = (ones >> lo) & ~(ones >> hi);
  assign masked = word & mask;

  always_comb begin
    first_sub = '0;
    last_sub  = '0;
    for (int p = 0; p < bme_pkg::WORD_BITS; p++) begin
      if (masked[p]) first_sub = bme_pkg::SUB_W'(bme_pkg::WORD_BITS - 1 - p);
    end
    for (int p = bme_pkg::WORD_BITS - 1; p >= 0; p--) begin
      if (masked[p]) last_sub = bme_pkg::SUB_W'(bme_pkg::WORD_BITS - 1 - p);
    end
  end

  assign res.modified  = value ? (word | mask) : (word & ~mask);
  assign res.any       = |masked;
  assign res.first_sub = first_sub;
  assign res.last_sub  = last_sub;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int WORD_BITS = bme_pkg::WORD_BITS;
  localparam int WORD_COUNT = bme_pkg::WORD_COUNT;
  localparam int OP_W = bme_pkg::OP_W;
  localparam int IDX_W = bme_pkg::IDX_W;
  localparam int CNT_W = bme_pkg::CNT_W;
  localparam int LIMIT_CYCLES = 800000;
  localparam int MAP_BITS = WORD_BITS * WORD_COUNT;
  localparam int PHASES = 12;
  localparam int REPORT_MAX = 50;
  localparam logic [2:0] REG_BITS_IN_USE = 3'd0;
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic             value;
    logic [IDX_W-1:0] index;
    logic [CNT_W-1:0] range_end;
  } request_t;

  typedef struct packed {
    logic             bit_value;
    logic             found;
    logic [IDX_W-1:0] found_index;
    logic             error;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OP_W-1:0] op = '0;
  logic value = 1'b0;
  logic [IDX_W-1:0] index = '0;
  logic [CNT_W-1:0] range_end = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic bit_value;
  logic found;
  logic [IDX_W-1:0] found_index;
  logic error;

  bit [MAP_BITS-1:0] map_bits = '0;
  logic [CNT_W-1:0] bits_in_use_cfg = bme_pkg::BITS_RESET;
  request_t pending_words[$];
  result_t expected_results[$];
  request_t offered;
  result_t want;
  int bits_plan [PHASES] = '{4096, 1, 0, 4095, 63, 64, 65, 100, 8191, 2000, 4096, 1000};
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int stall_cycles = 0;
  int hot_base = 0;
  int cycle_count = 0;
  int mismatch_count = 0;
  int results_checked = 0;
  int error_count = 0;
  int found_count = 0;
  int op_count [8] = '{default: 0};

  bitmap_engine_with_find_first_last uut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .value(value),
    .index(index),
    .range_end(range_end),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .bit_value(bit_value),
    .found(found),
    .found_index(found_index),
    .error(error)
  );

  always #5 clk = ~clk;

  function automatic int limit_of(logic [CNT_W-1:0] bits);
    return (int'(bits) < MAP_BITS) ? int'(bits) : MAP_BITS;
  endfunction

  function automatic result_t apply_request(request_t r);
    result_t res;
    int lim;
    res = '0;
    lim = limit_of(bits_in_use_cfg);
    case (r.op)
      bme_pkg::OP_READ: begin
        if (int'(r.index) >= lim) res.error = 1'b1;
        else res.bit_value = map_bits[r.index];
      end
      bme_pkg::OP_WRITE: begin
        if (int'(r.index) >= lim) res.error = 1'b1;
        else map_bits[r.index] = r.value;
      end
      bme_pkg::OP_RANGE: begin
        if (int'(r.index) > lim || int'(r.range_end) > lim) begin
          res.error = 1'b1;
        end else begin
          for (int i = int'(r.index); i < int'(r.range_end); i++) map_bits[i] = r.value;
        end
      end
      bme_pkg::OP_FIRST: begin
        for (int i = 0; i < lim; i++) begin
          if (map_bits[i]) begin
            res.found = 1'b1;
            res.found_index = IDX_W'(i);
            break;
          end
        end
      end
      bme_pkg::OP_LAST: begin
        for (int i = lim - 1; i >= 0; i--) begin
          if (map_bits[i]) begin
            res.found = 1'b1;
            res.found_index = IDX_W'(i);
            break;
          end
        end
      end
      bme_pkg::OP_CLEAR: map_bits = '0;
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [IDX_W-1:0] pick_index(int lim);
    int sel;
    sel = $urandom_range(9);
    if (sel < 2) return IDX_W'(lim - 1 + int'($urandom_range(2)));
    if (sel < 4 || lim == 0) return IDX_W'($urandom_range(MAP_BITS - 1));
    if (sel < 7) return IDX_W'((hot_base + int'($urandom_range(127))) % lim);
    return IDX_W'($urandom_range(lim - 1));
  endfunction

  function automatic request_t random_request(int lim);
    request_t r;
    int sel;
    sel = $urandom_range(99);
    if (sel < 22) r.op = bme_pkg::OP_READ;
    else if (sel < 45) r.op = bme_pkg::OP_WRITE;
    else if (sel < 60) r.op = bme_pkg::OP_RANGE;
    else if (sel < 73) r.op = bme_pkg::OP_FIRST;
    else if (sel < 86) r.op = bme_pkg::OP_LAST;
    else if (sel < 90) r.op = bme_pkg::OP_CLEAR;
    else if (sel < 95) r.op = $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
    else r.op = bme_pkg::OP_READ;
    r.value = 1'($urandom_range(1));
    r.index = pick_index(lim);
    case ($urandom_range(9))
      0: r.range_end = CNT_W'($urandom_range(8191));
      1: r.range_end = CNT_W'(lim);
      2: r.range_end = CNT_W'(int'(r.index) - int'($urandom_range(8)));
      default: r.range_end = CNT_W'(int'(r.index) + int'($urandom_range(150)));
    endcase
    return r;
  endfunction

  function automatic void queue_word(logic [OP_W-1:0] o, logic v, int i, int e);
    request_t r;
    r.op = o;
    r.value = v;
    r.index = IDX_W'(i);
    r.range_end = CNT_W'(e);
    pending_words.push_back(r);
  endfunction

  task automatic report_mismatch(string field, int got, int exp_val);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("tb: mismatch at word %0d: %s got %0d, expected %0d",
               results_checked, field, got, exp_val);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_drain();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_request(offered));
        op_count[offered.op]++;
      end
      if (!in_valid || in_ready) begin
        if (pending_words.size() > 0 && int'($urandom_range(99)) >= send_idle_pct) begin
          offered = pending_words.pop_front();
          in_valid <= 1'b1;
          op <= offered.op;
          value <= offered.value;
          index <= offered.index;
          range_end <= offered.range_end;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst || stall_cycles > 0) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= (int'($urandom_range(99)) >= recv_stall_pct);
    end
  end

  // long hold-off countdown
  always @(posedge clk) begin
    if (stall_cycles > 0) stall_cycles <= stall_cycles - 1;
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        want = expected_results.pop_front();
        if (bit_value !== want.bit_value)
          report_mismatch("bit_value", bit_value, want.bit_value);
        if (found !== want.found)
          report_mismatch("found", found, want.found);
        if (found_index !== want.found_index)
          report_mismatch("found_index", found_index, want.found_index);
        if (error !== want.error)
          report_mismatch("error", error, want.error);
        if (want.found) found_count++;
        if (want.error) error_count++;
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb: timeout after %0d cycles", cycle_count);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int lim;
    int count;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // directed words at the reset bit count
    queue_word(bme_pkg::OP_FIRST, 1'b0, 0, 0);
    queue_word(bme_pkg::OP_LAST, 1'b0, 0, 0);
    queue_word(bme_pkg::OP_WRITE, 1'b1, 0, 0);
    queue_word(bme_pkg::OP_WRITE, 1'b1, 4095, 0);
    queue_word(bme_pkg::OP_READ, 1'b0, 0, 0);
    queue_word(bme_pkg::OP_READ, 1'b0, 4095, 0);
    queue_word(bme_pkg::OP_READ, 1'b0, 1, 0);
    queue_word(bme_pkg::OP_FIRST, 1'b0, 0, 0);
    queue_word(bme_pkg::OP_LAST, 1'b0, 0, 0);
    queue_word(bme_pkg::OP_WRITE, 1'b0, 0, 0);
    queue_word(bme_pkg::OP_FIRST, 1'b0, 0, 0);
    queue_word(bme_pkg::OP_RANGE, 1'b1, 64, 130);
    queue_word(bme_pkg::OP_FIRST, 1'b0, 0, 0);
    queue_word(bme_pkg::OP_READ, 1'b0, 129, 0);
    queue_word(bme_pkg::OP_READ, 1'b0, 130, 0);
    queue_word(bme_pkg::OP_RANGE, 1'b1, 200, 100);
    queue_word(bme_pkg::OP_RANGE, 1'b1, 5, 5);
    queue_word(bme_pkg::OP_RANGE, 1'b1, 0, 4097);
    queue_word(bme_pkg::OP_RANGE, 1'b1, 4095, 8191);
    queue_word(bme_pkg::OP_RANGE, 1'b1, 0, 4096);
    queue_word(bme_pkg::OP_RANGE, 1'b0, 1, 4095);
    queue_word(bme_pkg::OP_LAST, 1'b0, 0, 0);
    queue_word(bme_pkg::OP_READ, 1'b0, 2048, 0);
    queue_word(bme_pkg::OP_CLEAR, 1'b0, 0, 0);
    queue_word(bme_pkg::OP_LAST, 1'b0, 0, 0);
    queue_word(OP_SPARE_A, 1'b1, 4095, 8191);
    queue_word(OP_SPARE_B, 1'b1, 4095, 8191);
    wait_drain();

    for (int p = 0; p < PHASES; p++) begin
      apb_write(REG_BITS_IN_USE, 32'(bits_plan[p]));
      bits_in_use_cfg = CNT_W'(bits_plan[p]);
      @(negedge clk);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      lim = limit_of(bits_in_use_cfg);
      hot_base = (lim > 0) ? int'($urandom_range(lim - 1)) : 0;
      count = (lim < 2) ? 40 : 130;
      for (int k = 0; k < count; k++) pending_words.push_back(random_request(lim));
      // hold the output side off while the input keeps offering
      if (p == 0) stall_cycles <= 300;
      wait_drain();
    end

    repeat (100) @(posedge clk);
    $display("tb: %0d words checked over %0d bits_in_use settings, %0d mismatches",
             results_checked, PHASES + 1, mismatch_count);
    $display("tb: read %0d write %0d range %0d first %0d last %0d clear %0d spare %0d",
             op_count[bme_pkg::OP_READ], op_count[bme_pkg::OP_WRITE],
             op_count[bme_pkg::OP_RANGE], op_count[bme_pkg::OP_FIRST],
             op_count[bme_pkg::OP_LAST], op_count[bme_pkg::OP_CLEAR],
             op_count[OP_SPARE_A] + op_count[OP_SPARE_B]);
    $display("tb: %0d errors, %0d hits", error_count, found_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/bme_pkg.sv
hdl/bme_word_unit.sv
hdl/bitmap_engine_with_find_first_last.sv
sim/testbench.sv
